// ===== sv/lzrw_pkg.sv =====
// Shared types and constants for the ring window token decoder.
// Used by the front end, token queue, back end and top level; depends on nothing.
package lzrw_pkg;

	localparam int unsigned WINDOW_DEPTH = 65536;
	localparam int unsigned WIN_AW = $clog2(WINDOW_DEPTH);
	localparam int unsigned BUF_DEPTH = 256;
	localparam int unsigned BUF_AW = $clog2(BUF_DEPTH);
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned DIST_W = 16;
	localparam int unsigned LEN_W = 8;
	localparam int unsigned CNT_W = 3;

	typedef enum logic {
		TOK_LIT   = 1'b0,
		TOK_MATCH = 1'b1
	} tok_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_COPY = 3'b100
	} back_state_t;

	typedef logic [WIN_AW-1:0] win_addr_t;

	typedef struct packed {
		tok_kind_t          kind;
		logic [BYTE_W-1:0]  lit;
		win_addr_t          start;
		logic [LEN_W-1:0]   len;
	} tok_t;

	typedef struct packed {
		logic valid;
		tok_t tok;
	} tok_slot_t;

endpackage

// ===== sv/lz_ring_window_token_decoder.sv =====
// Top level of the ring window token decoder: front end, token queue and back end.
// Depends on lzrw_pkg, lzrw_front, lzrw_queue and lzrw_back.
//
// Channel  Handshake              Payload per transfer
// input    in_valid / in_stall    func, literal_byte, distance, match_length
// output   out_valid / out_stall  byte0..byte3, byte_count, last_beat
//
// A literal is written to the window and output as a one-byte beat; a match of length L makes
// L reads through the single read port of the window RAM and L write-backs from the copy buffer.
// A zero-length match is dropped by the front end but still takes an input transfer.
// No clearing pass follows reset: a write pointer and a wrap flag make unwritten bytes read zero.
// in_stall rises while the two-entry token queue is full; out_stall holds back window reads.
module lz_ring_window_token_decoder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [lzrw_pkg::BYTE_W-1:0] literal_byte,
	input  logic [lzrw_pkg::DIST_W-1:0] distance,
	input  logic [lzrw_pkg::LEN_W-1:0]  match_length,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lzrw_pkg::BYTE_W-1:0] byte0,
	output logic [lzrw_pkg::BYTE_W-1:0] byte1,
	output logic [lzrw_pkg::BYTE_W-1:0] byte2,
	output logic [lzrw_pkg::BYTE_W-1:0] byte3,
	output logic [lzrw_pkg::CNT_W-1:0]  byte_count,
	output logic                        last_beat
);

	lzrw_pkg::tok_slot_t push;
	lzrw_pkg::tok_slot_t head;
	logic                q_full;
	logic                pop;

	lzrw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.literal_byte (literal_byte),
		.distance     (distance),
		.match_length (match_length),
		.q_full       (q_full),
		.push         (push)
	);

	lzrw_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	lzrw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.byte0      (byte0),
		.byte1      (byte1),
		.byte2      (byte2),
		.byte3      (byte3),
		.byte_count (byte_count),
		.last_beat  (last_beat)
	);

endmodule

// ===== sv/lzrw_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package dependency.
module lzrw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lzrw_front.sv =====
// Front end: accepts tokens, drops empty matches and works out each match's start address.
// Depends on lzrw_pkg; feeds lzrw_queue.
module lzrw_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            func,
	input  logic [lzrw_pkg::BYTE_W-1:0]     literal_byte,
	input  logic [lzrw_pkg::DIST_W-1:0]     distance,
	input  logic [lzrw_pkg::LEN_W-1:0]      match_length,
	input  logic                            q_full,
	output lzrw_pkg::tok_slot_t             push
);

	lzrw_pkg::win_addr_t shadow_q;
	lzrw_pkg::tok_kind_t kind;
	logic                accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign kind     = lzrw_pkg::tok_kind_t'(func);

	always_comb begin
		push.valid     = accept && ((kind == lzrw_pkg::TOK_LIT) || (match_length != '0));
		push.tok.kind  = kind;
		push.tok.lit   = literal_byte;
		push.tok.start = shadow_q - distance[lzrw_pkg::WIN_AW-1:0];
		push.tok.len   = match_length;
	end

	// The shadow index follows the write index that the back end will have reached.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow_q <= '0;
		end else if (accept) begin
			if (kind == lzrw_pkg::TOK_LIT) begin
				shadow_q <= shadow_q + lzrw_pkg::WIN_AW'(1);
			end else begin
				shadow_q <= shadow_q + lzrw_pkg::WIN_AW'(match_length);
			end
		end
	end

endmodule

// ===== sv/lzrw_queue.sv =====
// Short token queue between the front end and the back end.
// Depends on lzrw_pkg.
module lzrw_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  lzrw_pkg::tok_slot_t push,
	output logic                full,
	output lzrw_pkg::tok_slot_t head,
	input  logic                pop
);

	lzrw_pkg::tok_t                  entry_q [lzrw_pkg::QUEUE_DEPTH];
	logic [lzrw_pkg::QUEUE_AW-1:0]   wr_ptr_q;
	logic [lzrw_pkg::QUEUE_AW-1:0]   rd_ptr_q;
	logic [lzrw_pkg::QUEUE_AW:0]     count_q;

	assign full       = (count_q == (lzrw_pkg::QUEUE_AW + 1)'(lzrw_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.tok   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entry_q[wr_ptr_q] <= push.tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/lzrw_back.sv =====
// Back end: executes tokens against the ring window, packs output beats and writes back.
// Depends on lzrw_pkg and lzrw_ram (window and copy buffer).
module lzrw_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lzrw_pkg::tok_slot_t         head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [lzrw_pkg::BYTE_W-1:0] byte0,
	output logic [lzrw_pkg::BYTE_W-1:0] byte1,
	output logic [lzrw_pkg::BYTE_W-1:0] byte2,
	output logic [lzrw_pkg::BYTE_W-1:0] byte3,
	output logic [lzrw_pkg::CNT_W-1:0]  byte_count,
	output logic                        last_beat
);

	lzrw_pkg::back_state_t              state_q;
	lzrw_pkg::win_addr_t                wr_ptr_q;
	lzrw_pkg::win_addr_t                rd_addr_q;
	logic                               wrapped_q;
	logic [lzrw_pkg::LEN_W-1:0]         len_q;
	logic [lzrw_pkg::LEN_W-1:0]         rd_cnt_q;
	logic [lzrw_pkg::LEN_W-1:0]         cp_cnt_q;
	logic [lzrw_pkg::LEN_W-1:0]         rd_idx_s1;
	logic                               rd_pend_s1;
	logic                               rd_fill_s1;
	logic                               rd_last_s1;
	logic                               cp_pend_s1;
	logic                               cp_last_s1;
	logic [lzrw_pkg::BYTE_W-1:0]        asm_q [3];
	logic [1:0]                         asm_cnt_q;
	logic                               out_valid_q;
	logic [lzrw_pkg::BYTE_W-1:0]        out_byte_q [4];
	logic [lzrw_pkg::CNT_W-1:0]         out_cnt_q;
	logic                               out_last_q;

	logic                               out_free;
	logic                               in_read;
	logic                               in_copy;
	logic                               lit_go;
	logic                               match_go;
	logic [lzrw_pkg::BYTE_W-1:0]        cur_byte;
	logic                               rd_complete;
	logic                               rd_consume;
	logic                               rd_issue;
	logic                               cp_issue;
	logic                               beat_load;
	logic                               wr_adv;
	logic [lzrw_pkg::BYTE_W-1:0]        beat_byte [4];
	logic [lzrw_pkg::CNT_W-1:0]         beat_cnt;

	logic                               ring_we;
	logic [lzrw_pkg::BYTE_W-1:0]        ring_wdata;
	logic [lzrw_pkg::BYTE_W-1:0]        ring_rdata;
	logic [lzrw_pkg::BYTE_W-1:0]        buf_rdata;

	assign out_free    = !out_valid_q || !out_stall;
	assign in_read     = (state_q == lzrw_pkg::ST_READ);
	assign in_copy     = (state_q == lzrw_pkg::ST_COPY);
	assign lit_go      = (state_q == lzrw_pkg::ST_IDLE) && head.valid &&
	                     (head.tok.kind == lzrw_pkg::TOK_LIT) && out_free;
	assign match_go    = (state_q == lzrw_pkg::ST_IDLE) && head.valid &&
	                     (head.tok.kind == lzrw_pkg::TOK_MATCH);
	assign pop         = lit_go || match_go;

	// Bytes of the window that have never been written read as zero.
	assign cur_byte    = rd_fill_s1 ? ring_rdata : '0;
	assign rd_complete = (asm_cnt_q == 2'd3) || rd_last_s1;
	assign rd_consume  = in_read && rd_pend_s1 && (!rd_complete || out_free);
	assign rd_issue    = in_read && (rd_cnt_q != len_q) && (!rd_pend_s1 || rd_consume);
	assign beat_load   = rd_consume && rd_complete;
	assign cp_issue    = in_copy && (cp_cnt_q != len_q);
	assign wr_adv      = lit_go || cp_pend_s1;

	assign ring_we     = wr_adv;
	assign ring_wdata  = cp_pend_s1 ? buf_rdata : head.tok.lit;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < asm_cnt_q) begin
				beat_byte[i] = asm_q[i];
			end else if (2'(i) == asm_cnt_q) begin
				beat_byte[i] = cur_byte;
			end else begin
				beat_byte[i] = '0;
			end
		end
		beat_byte[3] = (asm_cnt_q == 2'd3) ? cur_byte : '0;
		beat_cnt     = lzrw_pkg::CNT_W'(asm_cnt_q) + lzrw_pkg::CNT_W'(1);
	end

	lzrw_ram #(
		.WIDTH (lzrw_pkg::BYTE_W),
		.DEPTH (lzrw_pkg::WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wr_ptr_q),
		.wdata (ring_wdata),
		.re    (rd_issue),
		.raddr (rd_addr_q),
		.rdata (ring_rdata)
	);

	lzrw_ram #(
		.WIDTH (lzrw_pkg::BYTE_W),
		.DEPTH (lzrw_pkg::BUF_DEPTH)
	) u_copy_buf (
		.clk   (clk),
		.we    (rd_consume),
		.waddr (lzrw_pkg::BUF_AW'(rd_idx_s1)),
		.wdata (cur_byte),
		.re    (cp_issue),
		.raddr (lzrw_pkg::BUF_AW'(cp_cnt_q)),
		.rdata (buf_rdata)
	);

	always_ff @(posedge clk) begin
		if (lit_go) begin
			out_byte_q[0] <= head.tok.lit;
			out_byte_q[1] <= '0;
			out_byte_q[2] <= '0;
			out_byte_q[3] <= '0;
			out_cnt_q     <= lzrw_pkg::CNT_W'(1);
			out_last_q    <= 1'b1;
		end else if (beat_load) begin
			out_byte_q <= beat_byte;
			out_cnt_q  <= beat_cnt;
			out_last_q <= rd_last_s1;
		end
		if (rd_consume && !rd_complete) begin
			asm_q[asm_cnt_q] <= cur_byte;
		end
		if (match_go) begin
			len_q     <= head.tok.len;
			rd_addr_q <= head.tok.start;
		end else if (rd_issue) begin
			rd_addr_q <= rd_addr_q + 1'b1;
		end
		if (rd_issue) begin
			rd_fill_s1 <= wrapped_q || (rd_addr_q < wr_ptr_q);
			rd_last_s1 <= (rd_cnt_q == len_q - 1'b1);
			rd_idx_s1  <= rd_cnt_q;
		end
		if (cp_issue) begin
			cp_last_s1 <= (cp_cnt_q == len_q - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lzrw_pkg::ST_IDLE;
			wr_ptr_q    <= '0;
			wrapped_q   <= 1'b0;
			rd_cnt_q    <= '0;
			cp_cnt_q    <= '0;
			rd_pend_s1  <= 1'b0;
			cp_pend_s1  <= 1'b0;
			asm_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_adv) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
				if (&wr_ptr_q) begin
					wrapped_q <= 1'b1;
				end
			end

			if (lit_go || beat_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (rd_issue) begin
				rd_pend_s1 <= 1'b1;
				rd_cnt_q   <= rd_cnt_q + 1'b1;
			end else if (rd_consume) begin
				rd_pend_s1 <= 1'b0;
			end

			if (rd_consume) begin
				asm_cnt_q <= rd_complete ? 2'd0 : asm_cnt_q + 1'b1;
			end

			if (cp_issue) begin
				cp_pend_s1 <= 1'b1;
				cp_cnt_q   <= cp_cnt_q + 1'b1;
			end else begin
				cp_pend_s1 <= 1'b0;
			end

			unique case (state_q)
				lzrw_pkg::ST_IDLE: begin
					if (match_go) begin
						rd_cnt_q <= '0;
						cp_cnt_q <= '0;
						state_q  <= lzrw_pkg::ST_READ;
					end
				end
				lzrw_pkg::ST_READ: begin
					if (rd_consume && rd_last_s1) begin
						state_q <= lzrw_pkg::ST_COPY;
					end
				end
				lzrw_pkg::ST_COPY: begin
					if (cp_pend_s1 && cp_last_s1) begin
						state_q <= lzrw_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= lzrw_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign byte0      = out_byte_q[0];
	assign byte1      = out_byte_q[1];
	assign byte2      = out_byte_q[2];
	assign byte3      = out_byte_q[3];
	assign byte_count = out_cnt_q;
	assign last_beat  = out_last_q;

endmodule

// ===== sv/lzrw_checker.sv =====
// Port-level checker for the ring window token decoder, bound to the top level.
// Depends on the top level's ports only.
module lzrw_port_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] byte0,
	input logic [7:0] byte1,
	input logic [7:0] byte2,
	input logic [7:0] byte3,
	input logic [2:0] byte_count,
	input logic       last_beat
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(byte0) && $stable(byte1) &&
			$stable(byte2) && $stable(byte3) && $stable(byte_count) && $stable(last_beat))
		else $error("stalled output transfer changed");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (byte_count != 3'd0) && (byte_count <= 3'd4))
		else $error("byte count out of range");

	a_short_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_count != 3'd4) |-> last_beat)
		else $error("partial beat not marked last");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((byte_count > 3'd1) || (byte1 == 8'd0)) &&
			((byte_count > 3'd2) || (byte2 == 8'd0)) &&
			((byte_count > 3'd3) || (byte3 == 8'd0)))
		else $error("unused byte lane not zero");

endmodule

bind lz_ring_window_token_decoder lzrw_port_checks u_lzrw_port_checks (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.byte0      (byte0),
	.byte1      (byte1),
	.byte2      (byte2),
	.byte3      (byte3),
	.byte_count (byte_count),
	.last_beat  (last_beat)
);
